### hw/rtl/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg: shared types and constants of the Golomb gap-list decoder
// Item types of the coded and decoded channels, the arming record passed
// from the register block to the decoder, and the code width helper.
// ----------------------------------------------------------------------------
package gld_pkg;

	// Field and state widths.
	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 16;
	localparam int M_W       = 16;
	localparam int CW_W      = 5;
	localparam int REM_W     = 16;
	localparam int RB_W      = 4;
	localparam int BYTE_W    = 8;
	localparam int BITCNT_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_GOLOMB_M      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_MODE = 2'd2;

	// One coded item: a byte of the bitstream and its end marker.
	typedef struct packed {
		logic [BYTE_W-1:0] coded_byte;
		logic              final_byte;
	} gld_in_t;

	// One decoded item.
	typedef struct packed {
		logic [VALUE_W-1:0] decoded_value;
		logic               last_value;
		logic               truncated;
	} gld_out_t;

	// Everything the decoder latches when a new list is armed.
	typedef struct packed {
		logic                 arm;
		logic [CFG_DAT_W-1:0] count;
		logic                 pos_mode;
		logic [M_W-1:0]       m;
		logic [CW_W-1:0]      width;
		logic [M_W-1:0]       thresh;
	} gld_arm_t;

	// Smallest b with 2^b >= m, for a nonzero m.
	function automatic logic [CW_W-1:0] code_width_of(input logic [M_W-1:0] m);
		logic [M_W-1:0]  mm;
		logic [CW_W-1:0] w;
		mm = m - M_W'(1);
		w  = '0;
		for (int i = 0; i < M_W; i++) begin
			if (mm[i]) begin
				w = CW_W'(i + 1);
			end
		end
		return w;
	endfunction

endpackage

### hw/rtl/gld_cfg.sv
// ----------------------------------------------------------------------------
// gld_cfg: configuration registers
// Holds the divisor and the position mode. A write of the value count arms a
// new list and hands the derived code width and threshold to the decoder.
// ----------------------------------------------------------------------------
module gld_cfg
	import gld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 busy,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output gld_arm_t             arm
);

	logic                 wr;
	logic [M_W-1:0]       golomb_m_q;
	logic                 pos_mode_q;
	logic [M_W-1:0]       m_eff;
	logic [CW_W-1:0]      width;
	logic [M_W:0]         span;

	// Writes are taken whenever no byte is being decoded.
	assign cfg_ready = !busy;
	assign wr        = cfg_valid && cfg_ready;

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			golomb_m_q <= M_W'(1);
			pos_mode_q <= 1'b0;
		end else if (wr) begin
			case (cfg_index)
				REG_GOLOMB_M:      golomb_m_q <= cfg_data[M_W-1:0];
				REG_POSITION_MODE: pos_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A divisor of zero behaves as one; derive b and t = 2^b - m.
	always_comb begin
		m_eff = (golomb_m_q == '0) ? M_W'(1) : golomb_m_q;
		width = code_width_of(m_eff);
		span  = ((M_W+1)'(1) << width) - {1'b0, m_eff};
	end

	assign arm.arm      = wr && (cfg_index == REG_VALUE_COUNT);
	assign arm.count    = cfg_data;
	assign arm.pos_mode = pos_mode_q;
	assign arm.m        = m_eff;
	assign arm.width    = width;
	assign arm.thresh   = span[M_W-1:0];

endmodule

### hw/rtl/gld_dec.sv
// ----------------------------------------------------------------------------
// gld_dec: bit-serial codeword decoder
// Shifts each accepted byte out MSB first, one bit per cycle unless a value
// waits for the result side, through the unary, remainder body and extra-bit
// phases, and forms one value per codeword with a single running accumulator.
// ----------------------------------------------------------------------------
module gld_dec
	import gld_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  gld_arm_t arm,
	input  logic     code_valid,
	output logic     code_stall,
	input  gld_in_t  code_item,
	output logic     busy,
	output logic     res_valid,
	output gld_out_t res_item,
	input  logic     res_ready
);

	typedef enum logic [1:0] {
		PH_UNARY,
		PH_BODY,
		PH_EXTRA
	} phase_t;

	phase_t               phase_q;
	logic                 busy_q;
	logic                 final_q;
	logic [BYTE_W-1:0]    shift_q;
	logic [BITCNT_W-1:0]  bit_cnt_q;
	logic                 list_active_q;
	logic [COUNT_W-1:0]   values_left_q;
	logic [VALUE_W-1:0]   acc_q;
	logic                 over_q;
	logic [M_W-1:0]       m_q;
	logic [CW_W-1:0]      width_q;
	logic [M_W-1:0]       thresh_q;
	logic [REM_W-1:0]     rem_q;
	logic [RB_W-1:0]      rbits_q;
	logic [REM_W-1:0]     d0_q;
	logic [REM_W-1:0]     d1_q;

	logic                 bit_in;
	logic                 last_bit;
	logic                 emit;
	logic                 take_q;
	logic                 to_body;
	logic                 to_extra;
	logic [REM_W-1:0]     rem_new;
	logic [RB_W-1:0]      rbits_new;
	logic [REM_W-1:0]     rem_src;
	logic [REM_W-1:0]     d0;
	logic [REM_W-1:0]     d1;
	logic [VALUE_W-1:0]   addend;
	logic [VALUE_W:0]     sum;
	logic [VALUE_W:0]     sum_inc;
	logic                 sat;
	logic [VALUE_W-1:0]   value;
	logic                 at_max;
	logic                 emit_last;
	logic                 fin;
	logic                 produce;
	logic                 exec;
	logic                 byte_end;
	logic                 done_now;
	logic                 accept;

	assign bit_in   = shift_q[BYTE_W-1];
	assign last_bit = (bit_cnt_q == '1);

	// Next-state decision for the bit at the head of the shift register.
	always_comb begin
		emit      = 1'b0;
		take_q    = 1'b0;
		to_body   = 1'b0;
		to_extra  = 1'b0;
		addend    = '0;
		rem_new   = {rem_q[REM_W-2:0], bit_in};
		rbits_new = rbits_q + RB_W'(1);
		rem_src   = '0;
		unique case (phase_q)
			PH_UNARY: begin
				if (bit_in) begin
					take_q = 1'b1;
					addend = VALUE_W'(m_q);
				end else if (width_q == '0) begin
					emit = 1'b1;
				end else if (width_q == CW_W'(1)) begin
					if (thresh_q == '0) begin
						to_extra = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end else begin
					to_body = 1'b1;
				end
			end
			PH_BODY: begin
				addend  = VALUE_W'(rem_new);
				rem_src = rem_new;
				if ({1'b0, rbits_new} >= (width_q - CW_W'(1))) begin
					if (rem_new >= thresh_q) begin
						to_extra = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
			end
			PH_EXTRA: begin
				emit   = 1'b1;
				addend = VALUE_W'(bit_in ? d1_q : d0_q);
			end
			default: ;
		endcase
	end

	// Both candidate remainders of the extra bit, ready before that bit arrives.
	assign d0 = {rem_src[REM_W-2:0], 1'b0} - thresh_q;
	assign d1 = {rem_src[REM_W-2:0], 1'b1} - thresh_q;

	// Running value plus quotient plus remainder, saturated at the maximum.
	always_comb begin
		sum     = {1'b0, acc_q} + {1'b0, addend};
		sum_inc = {1'b0, acc_q} + {1'b0, addend} + (VALUE_W+1)'(1);
		sat     = over_q || sum[VALUE_W];
		value   = sat ? '1 : sum[VALUE_W-1:0];
		at_max  = &value;
	end

	// Result production and the end of the current byte.
	always_comb begin
		emit_last  = emit && (values_left_q == COUNT_W'(1));
		fin        = final_q && last_bit && !emit_last;
		produce    = emit || fin;
		exec       = busy_q && list_active_q && (!produce || res_ready);
		byte_end   = last_bit || emit_last;
		done_now   = (exec && byte_end) || (busy_q && !list_active_q);
		code_stall = busy_q && !done_now;
		accept     = code_valid && !code_stall;
	end

	assign busy                   = busy_q;
	assign res_valid              = exec && produce;
	assign res_item.decoded_value = value;
	assign res_item.last_value    = emit_last || fin;
	assign res_item.truncated     = sat || fin;

	// Byte shifter, list state and codeword state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			final_q       <= 1'b0;
			shift_q       <= '0;
			bit_cnt_q     <= '0;
			phase_q       <= PH_UNARY;
			list_active_q <= 1'b0;
			values_left_q <= '0;
			acc_q         <= '0;
			over_q        <= 1'b0;
			m_q           <= M_W'(1);
			width_q       <= '0;
			thresh_q      <= '0;
			rem_q         <= '0;
			rbits_q       <= '0;
			d0_q          <= '0;
			d1_q          <= '0;
		end else begin
			// Byte intake and bit shifting.
			if (accept) begin
				busy_q    <= 1'b1;
				shift_q   <= code_item.coded_byte;
				final_q   <= code_item.final_byte;
				bit_cnt_q <= '0;
			end else if (done_now) begin
				busy_q <= 1'b0;
			end else if (exec) begin
				shift_q   <= {shift_q[BYTE_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + BITCNT_W'(1);
			end

			// Arming a list, or one decode step.
			if (arm.arm) begin
				list_active_q <= (arm.count[COUNT_W-1:0] != '0);
				values_left_q <= arm.count[COUNT_W-1:0];
				acc_q         <= arm.pos_mode ? '0 : VALUE_W'(1);
				over_q        <= 1'b0;
				phase_q       <= PH_UNARY;
				m_q           <= arm.m;
				width_q       <= arm.width;
				thresh_q      <= arm.thresh;
				rem_q         <= '0;
				rbits_q       <= '0;
			end else if (exec) begin
				if (fin) begin
					// Data ran out with the list still open: close it.
					list_active_q <= 1'b0;
					values_left_q <= '0;
					phase_q       <= PH_UNARY;
				end else if (emit) begin
					values_left_q <= values_left_q - COUNT_W'(1);
					phase_q       <= PH_UNARY;
					if (emit_last) begin
						list_active_q <= 1'b0;
					end
				end else if (to_body) begin
					phase_q <= PH_BODY;
					rem_q   <= '0;
					rbits_q <= '0;
				end else if (to_extra) begin
					phase_q <= PH_EXTRA;
					rem_q   <= rem_src;
					d0_q    <= d0;
					d1_q    <= d1;
				end else if (phase_q == PH_BODY) begin
					rem_q   <= rem_new;
					rbits_q <= rbits_new;
				end
				// Running value after a finished value or one more quotient step.
				if (emit) begin
					acc_q  <= at_max ? '1 : sum_inc[VALUE_W-1:0];
					over_q <= at_max;
				end else if (take_q) begin
					acc_q  <= value;
					over_q <= sat;
				end
			end
		end
	end

endmodule

### hw/rtl/gld_oreg.sv
// ----------------------------------------------------------------------------
// gld_oreg: output register
// One-entry register between the decoder and the result channel, so the
// decoder keeps going while a finished item waits to be taken.
// ----------------------------------------------------------------------------
module gld_oreg
	import gld_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     res_valid,
	input  gld_out_t res_item,
	output logic     res_ready,
	output logic     value_valid,
	input  logic     value_stall,
	output gld_out_t value_item
);

	logic     valid_q;
	gld_out_t item_q;

	// Room for a new item when empty or when the held item leaves now.
	assign res_ready   = !valid_q || !value_stall;
	assign value_valid = valid_q;
	assign value_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			item_q  <= '0;
		end else if (res_ready) begin
			valid_q <= res_valid;
			if (res_valid) begin
				item_q <= res_item;
			end
		end
	end

endmodule

### hw/rtl/golomb_gap_list_decoder_top.sv
// The bits of a taken byte are decoded in order, MSB first, through the byte
// shift register; a value formed from a bit shows on the result port in the
// next cycle, from the output register. The shifter moves one bit per cycle;
// stalls on the result side hold the bit that would emit.
// Bytes arriving with no list armed are dropped.
// Reset (arst_n low) closes any list and sets golomb_m to 1, the rest to 0.
// ----------------------------------------------------------------------------
// golomb_gap_list_decoder_top: Golomb gap-list decoder
// Decodes a Golomb-coded gap list with truncated-binary remainders into
// running document ids or positions, with truncation and saturation flags.
// ----------------------------------------------------------------------------
module golomb_gap_list_decoder_top
	import gld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 code_valid,
	output logic                 code_stall,
	input  gld_in_t              code_item,
	output logic                 value_valid,
	input  logic                 value_stall,
	output gld_out_t             value_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	gld_arm_t arm;
	logic     busy;
	logic     res_valid;
	logic     res_ready;
	gld_out_t res_item;

	// Configuration registers and list arming.
	gld_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.arm       (arm)
	);

	// Bit-serial decoder.
	gld_dec u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.arm        (arm),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_item  (code_item),
		.busy       (busy),
		.res_valid  (res_valid),
		.res_item   (res_item),
		.res_ready  (res_ready)
	);

	// Result register.
	gld_oreg u_oreg (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res_item    (res_item),
		.res_ready   (res_ready),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value_item  (value_item)
	);

endmodule

### hw/rtl/gld_checker.sv
// ----------------------------------------------------------------------------
// gld_checker: port-level checks of the Golomb gap-list decoder
// Watches the top-level ports only and is attached by the bind below.
// ----------------------------------------------------------------------------
module gld_checker
	import gld_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 code_valid,
	input logic                 code_stall,
	input gld_in_t              code_item,
	input logic                 value_valid,
	input logic                 value_stall,
	input gld_out_t             value_item,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DAT_W-1:0] cfg_data
);

	// A stalled result item stays put.
	a_value_hold: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_stall |=> value_valid && $stable(value_item))
		else $error("result item changed while stalled");

	// While a byte is in flight, configuration writes are refused.
	a_busy_no_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		code_stall |-> !cfg_ready)
		else $error("configuration open while a byte is decoding");

	// A taken byte always occupies the decoder for the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_stall |=> !cfg_ready)
		else $error("decoder idle right after taking a byte");

	// A flagged value that does not close the list can only be a saturated one.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_item.truncated && !value_item.last_value
		|-> &value_item.decoded_value)
		else $error("truncated flag on a value below the maximum");

endmodule

bind golomb_gap_list_decoder_top gld_checker u_gld_checker (.*);

### test/gld_value_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_value_checker: scoreboard for the Golomb gap-list decoder
// Watches the register, coded and decoded channels, keeps its own copy of the
// decoder state, works out the decoded items each accepted byte should give
// and compares every decoded item with the oldest one still awaited.
// ----------------------------------------------------------------------------
module gld_value_checker
	import gld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 code_valid,
	input  logic                 code_stall,
	input  gld_in_t              code_item,
	input  logic                 value_valid,
	input  logic                 value_stall,
	input  gld_out_t             value_item,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   mismatches,
	output int                   outstanding,
	output int                   values_checked
);

	localparam logic [63:0] VALUE_CAP = (64'd1 << VALUE_W) - 64'd1;
	localparam int MAX_PER_BYTE = 8;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		PH_UNARY,
		PH_BODY,
		PH_EXTRA
	} phase_t;

	// Register copies.
	logic [M_W-1:0]     reg_m;
	logic               reg_pos;

	// Decoder state of the current list.
	logic [M_W:0]       list_m;
	logic [CW_W-1:0]    width_b;
	logic [M_W:0]       thresh_t;
	logic [63:0]        quot_sum;
	bit                 quot_over;
	logic [M_W:0]       rem_acc;
	logic [CW_W-1:0]    rem_cnt;
	phase_t             phase;
	logic [63:0]        run_value;
	bit                 run_over;
	logic [COUNT_W-1:0] left;
	bit                 active;

	gld_out_t awaited_values[$];
	gld_out_t step_out[MAX_PER_BYTE];
	int       step_n;

	// Addition that pins at the largest value and raises the overflow flag.
	function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b,
			inout bit over);
		if (a > VALUE_CAP || b > VALUE_CAP - a) begin
			over = 1'b1;
			return VALUE_CAP;
		end
		return a + b;
	endfunction

	function automatic void clear_codeword();
		quot_sum  = '0;
		quot_over = 1'b0;
		rem_acc   = '0;
		rem_cnt   = '0;
		phase     = PH_UNARY;
	endfunction

	function automatic void model_reset();
		reg_m     = M_W'(1);
		reg_pos   = 1'b0;
		list_m    = 17'd1;
		width_b   = '0;
		thresh_t  = '0;
		clear_codeword();
		run_value = '0;
		run_over  = 1'b0;
		left      = '0;
		active    = 1'b0;
	endfunction

	// Writing the count starts a new list with the divisor and mode held now.
	function automatic void arm_decode(input logic [CFG_DAT_W-1:0] count);
		logic [M_W:0] mm;
		logic [M_W:0] span;
		int           bits;
		mm   = (reg_m == '0) ? 17'd1 : {1'b0, reg_m};
		span = 17'd1;
		bits = 0;
		while (mm > span) begin
			bits++;
			span = span << 1;
		end
		list_m    = mm;
		width_b   = CW_W'(bits);
		thresh_t  = span - mm;
		left      = count[COUNT_W-1:0];
		run_value = reg_pos ? 64'd0 : 64'd1;
		run_over  = 1'b0;
		clear_codeword();
		active    = (left != '0);
	endfunction

	// Previous value plus one plus quotient plus remainder, saturating.
	function automatic logic [63:0] form_decoded(input logic [63:0] rem, output bit over);
		bit          o;
		logic [63:0] v;
		o = run_over || quot_over;
		v = capped_sum(run_value, quot_sum, o);
		v = capped_sum(v, rem, o);
		if (o) begin
			v = VALUE_CAP;
		end
		over = o;
		return v;
	endfunction

	function automatic void emit_decoded(input logic [63:0] rem);
		bit          over;
		logic [63:0] v;
		logic        is_last;
		v       = form_decoded(rem, over);
		left    = left - 1'b1;
		is_last = (left == '0);
		step_out[step_n].decoded_value = v[VALUE_W-1:0];
		step_out[step_n].last_value    = is_last;
		step_out[step_n].truncated     = over;
		step_n++;
		if (v >= VALUE_CAP) begin
			run_value = VALUE_CAP;
			run_over  = 1'b1;
		end else begin
			run_value = v + 64'd1;
		end
		clear_codeword();
		if (is_last) begin
			active = 1'b0;
		end
	endfunction

	// One bit of the stream through the unary, body and extra-bit phases.
	function automatic void take_coded_bit(input logic b);
		logic [M_W:0] x;
		case (phase)
			PH_UNARY: begin
				if (b) begin
					quot_sum = capped_sum(quot_sum, 64'(list_m), quot_over);
				end else if (width_b == '0) begin
					emit_decoded(64'd0);
				end else begin
					rem_acc = '0;
					rem_cnt = '0;
					if (width_b == CW_W'(1)) begin
						if (thresh_t == '0) begin
							phase = PH_EXTRA;
						end else begin
							emit_decoded(64'd0);
						end
					end else begin
						phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				rem_acc = {rem_acc[M_W-1:0], b};
				rem_cnt = rem_cnt + 1'b1;
				if (rem_cnt >= width_b - 1) begin
					if (rem_acc >= thresh_t) begin
						phase = PH_EXTRA;
					end else begin
						emit_decoded(64'(rem_acc));
					end
				end
			end
			default: begin
				x = {rem_acc[M_W-1:0], b};
				emit_decoded(64'(32'(x) - 32'(thresh_t)));
			end
		endcase
	endfunction

	// Decoded items caused by one accepted byte, queued in order.
	function automatic void decode_coded_byte(input gld_in_t it);
		bit          started;
		bit          over;
		logic [63:0] v;
		step_n = 0;
		if (!active) begin
			return;
		end
		for (int i = BYTE_W - 1; i >= 0 && active; i--) begin
			take_coded_bit(it.coded_byte[i]);
		end
		// The data runs out while the list is still open.
		if (it.final_byte && active) begin
			started = (phase != PH_UNARY) || (quot_sum != '0) || quot_over;
			if (started && step_n < MAX_PER_BYTE) begin
				v = form_decoded((phase == PH_UNARY) ? 64'd0 : 64'(rem_acc), over);
				step_out[step_n].decoded_value = v[VALUE_W-1:0];
				step_out[step_n].last_value    = 1'b1;
				step_out[step_n].truncated     = 1'b1;
				step_n++;
			end else if (step_n > 0) begin
				step_out[step_n-1].last_value = 1'b1;
				step_out[step_n-1].truncated  = 1'b1;
			end
			active = 1'b0;
			left   = '0;
			clear_codeword();
		end
		for (int k = 0; k < step_n; k++) begin
			awaited_values.push_back(step_out[k]);
		end
	endfunction

	function automatic void note_mismatch();
		mismatches++;
	endfunction

	// Compare first, then take register writes and bytes of this edge.
	always @(posedge clk or negedge arst_n) begin
		gld_out_t want;
		if (!arst_n) begin
			model_reset();
			awaited_values.delete();
			mismatches     = 0;
			values_checked = 0;
			outstanding   <= 0;
		end else begin
			if (value_valid && !value_stall) begin
				values_checked++;
				if (awaited_values.size() == 0) begin
					note_mismatch();
					if (mismatches <= REPORT_LIMIT) begin
						$display("[%0t] decoded item with none awaited: value %0d last %0b trunc %0b",
							$time, value_item.decoded_value, value_item.last_value,
							value_item.truncated);
					end
				end else begin
					want = awaited_values.pop_front();
					if (want.decoded_value !== value_item.decoded_value ||
							want.last_value !== value_item.last_value ||
							want.truncated !== value_item.truncated) begin
						note_mismatch();
						if (mismatches <= REPORT_LIMIT) begin
							$display("[%0t] decoded item mismatch: want %0d/%0b/%0b got %0d/%0b/%0b",
								$time, want.decoded_value, want.last_value, want.truncated,
								value_item.decoded_value, value_item.last_value,
								value_item.truncated);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GOLOMB_M: reg_m = cfg_data[M_W-1:0];
					REG_VALUE_COUNT: arm_decode(cfg_data);
					REG_POSITION_MODE: reg_pos = cfg_data[0];
					default: ;
				endcase
			end
			if (code_valid && !code_stall) begin
				decode_coded_byte(code_item);
			end
			outstanding <= awaited_values.size();
		end
	end

endmodule

### test/golomb_gap_list_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// golomb_gap_list_decoder_top_tb: stimulus and verdict for the gap decoder
// Arms lists through the register port and feeds coded bytes: a directed set
// of lists for each phase of a codeword and for stream ends, then random
// lists built by a small encoder, with random idling on both sides.
// ----------------------------------------------------------------------------
module golomb_gap_list_decoder_top_tb;
	import gld_pkg::*;

	localparam int IDLE_PCT      = 19;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_BYTES  = 420;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 code_valid = 1'b0;
	logic                 code_stall;
	gld_in_t              code_item = '0;
	logic                 value_valid;
	logic                 value_stall = 1'b0;
	gld_out_t             value_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int values_checked;
	int idle_cycles = 0;
	int bytes_sent = 0;
	int lists_run = 0;
	int random_bytes = 0;
	int enc_m = 1;
	bit steady = 1'b0;
	bit coded_bits[$];

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	golomb_gap_list_decoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_item  (code_item),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value_item (value_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	gld_value_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code_item     (code_item),
		.value_valid   (value_valid),
		.value_stall   (value_stall),
		.value_item    (value_item),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.values_checked(values_checked)
	);

	// Random back-pressure on the decoded side, off while steady.
	always @(posedge clk) begin
		value_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog: too long without any item moving on any channel.
	always @(posedge clk) begin
		if (!arst_n || (code_valid && !code_stall) || (value_valid && !value_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Valid stays high from one write to the next; the caller lowers it.
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic arm_list(input int m, input logic pos, input int count);
		reg_write(REG_GOLOMB_M, CFG_DAT_W'(m));
		reg_write(REG_POSITION_MODE, CFG_DAT_W'(pos));
		reg_write(REG_VALUE_COUNT, CFG_DAT_W'(count));
		cfg_valid <= 1'b0;
		enc_m = (m == 0) ? 1 : m;
		lists_run++;
	endtask

	// Offer one coded item after a random gap; valid is left high.
	task automatic send_byte(input logic [BYTE_W-1:0] data, input logic fin);
		gld_in_t it;
		it.coded_byte = data;
		it.final_byte = fin;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code_valid <= 1'b1;
		code_item  <= it;
		do @(posedge clk); while (code_stall);
		bytes_sent++;
	endtask

	// Wait for every awaited item, then for the last byte's bits to clear.
	task automatic wait_idle();
		code_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Golomb codeword of one gap under the current divisor.
	function automatic void put_gap(input int unsigned gap);
		int          bits;
		int unsigned span;
		int unsigned t;
		int unsigned q;
		int unsigned r;
		bits = 0;
		span = 1;
		while (enc_m > span) begin
			bits++;
			span = span << 1;
		end
		t = span - enc_m;
		q = gap / enc_m;
		r = gap % enc_m;
		repeat (q) coded_bits.push_back(1'b1);
		coded_bits.push_back(1'b0);
		if (bits > 0) begin
			if (r < t) begin
				for (int i = bits - 2; i >= 0; i--) coded_bits.push_back(r[i]);
			end else begin
				for (int i = bits - 1; i >= 0; i--) coded_bits.push_back(1'(((r + t) >> i) & 1));
			end
		end
	endfunction

	// Pack the pending bits MSB first; the tail of the last byte is random.
	task automatic send_bits(input logic fin);
		logic [BYTE_W-1:0] data;
		int                nb;
		nb = (coded_bits.size() + 7) / 8;
		for (int k = 0; k < nb; k++) begin
			data = BYTE_W'($urandom_range(255));
			for (int i = BYTE_W - 1; i >= 0; i--) begin
				if (coded_bits.size() != 0) data[i] = coded_bits.pop_front();
			end
			send_byte(data, fin && (k == nb - 1));
		end
	endtask

	function automatic int unsigned random_gap();
		int unsigned q;
		if (enc_m > 1000) q = $urandom_range(2);
		else if ($urandom_range(9) == 0) q = $urandom_range(20);
		else q = $urandom_range(3);
		return q * enc_m + $urandom_range(enc_m - 1);
	endfunction

	// One random list: mostly whole gap lists, some cut short, some noise.
	task automatic random_list();
		int m;
		int count;
		int k;
		int n;
		int cut;
		int start_count;
		logic pos;
		case ($urandom_range(19))
			0: m = 0;
			1: m = 65535;
			2, 3: m = $urandom_range(2, 1);
			4: m = $urandom_range(65535, 1001);
			5, 6, 7: m = $urandom_range(1000, 41);
			default: m = $urandom_range(40, 3);
		endcase
		case ($urandom_range(19))
			0: count = 0;
			1: count = 65535;
			2, 3: count = $urandom_range(40, 11);
			default: count = $urandom_range(10, 1);
		endcase
		pos = 1'($urandom_range(1));
		steady <= (lists_run >= 20 && lists_run < 32);
		arm_list(m, pos, count);
		start_count = bytes_sent;
		k = (count > 40) ? $urandom_range(12, 1) : count;
		if (count == 0) begin
			// No list armed: these bytes are dropped.
			repeat ($urandom_range(3, 1)) send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
		end else begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
					repeat (k) put_gap(random_gap());
					send_bits((count > 40) ? 1'b1 : 1'($urandom_range(1)));
				end
				11, 12, 13, 14: begin
					n = (k > 1) ? $urandom_range(k - 1, 1) : 1;
					repeat (n) put_gap(random_gap());
					send_bits(1'b1);
				end
				15, 16, 17: begin
					repeat (k) put_gap(random_gap());
					if (coded_bits.size() > 1) begin
						cut = $urandom_range(coded_bits.size() - 1, 1);
						repeat (cut) void'(coded_bits.pop_back());
					end
					send_bits(1'b1);
				end
				default: begin
					repeat ($urandom_range(6, 1)) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
					send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
				end
			endcase
			random_bytes += bytes_sent - start_count;
		end
		wait_idle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A byte with no list armed is dropped.
		send_byte(8'hA5, 1'b1);
		wait_idle();

		// Spare register index is ignored; divisor zero acts as one.
		reg_write(REG_SPARE, 16'hFFFF);
		arm_list(0, 1'b0, 3);
		put_gap(0);
		put_gap(0);
		put_gap(1);
		send_bits(1'b0);
		wait_idle();

		// Unary quotient spanning a whole byte.
		arm_list(1, 1'b0, 2);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		wait_idle();

		// One-bit code width, position mode.
		arm_list(2, 1'b1, 4);
		put_gap(0);
		put_gap(1);
		put_gap(2);
		put_gap(3);
		send_bits(1'b0);
		wait_idle();

		// Short and long remainders; the list ends inside the final byte.
		arm_list(5, 1'b0, 5);
		put_gap(0);
		put_gap(2);
		put_gap(3);
		put_gap(4);
		put_gap(7);
		send_bits(1'b1);
		wait_idle();

		// Largest divisor.
		arm_list(65535, 1'b1, 2);
		put_gap(65534);
		put_gap(131070);
		send_bits(1'b0);
		wait_idle();

		// Data ends on a codeword boundary (eight values), then in a quotient (four).
		arm_list(1, 1'b0, 20);
		send_byte(8'h00, 1'b1);
		wait_idle();
		arm_list(2, 1'b1, 9);
		send_byte(8'h1B, 1'b1);
		wait_idle();

		// Data ends inside the remainder body, the quotient and the extra bit.
		arm_list(5, 1'b0, 4);
		send_byte(8'hFE, 1'b1);
		wait_idle();
		arm_list(7, 1'b1, 3);
		send_byte(8'hFF, 1'b1);
		wait_idle();
		arm_list(9, 1'b0, 2);
		send_byte(8'hF7, 1'b1);
		wait_idle();

		while (random_bytes < RANDOM_BYTES) random_list();

		$display("Covered %0d coded bytes over %0d lists; %0d decoded items checked.",
			bytes_sent, lists_run, values_checked);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
